@@ design/srrw_pkg.sv @@
package srrw_pkg;

    localparam int WINDOW    = 4;   // power of two: slot index is the low bits of seq
    localparam int SEQ_BITS  = 16;
    localparam int SLOT_BITS = $clog2(WINDOW);
    localparam int TAG_BITS  = 32;
    localparam int CHK_BITS  = 8;

    localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_BITS-1:0]        seq_no;
        logic                       final_packet;
        logic [TAG_BITS-1:0]        payload_tag;
        logic signed [CHK_BITS-1:0] payload_check;
    } request_t;

    typedef struct packed {
        logic                       kind;
        logic [SEQ_BITS-1:0]        out_seq;
        logic signed [CHK_BITS-1:0] ack_check;
        logic [TAG_BITS-1:0]        out_tag;
        logic                       file_done;
        logic                       run_end;
    } result_t;

    typedef struct packed {
        logic latch;
        logic eval;
        logic drain;
    } cmd_t;

    typedef struct packed {
        logic in_win;
        logic is_base;
        logic session_over;
        logic drain_last;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

@@ design/srrw_ctrl.sv @@
module srrw_ctrl
    import srrw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!status.session_over && status.in_win && status.is_base)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                cmd.drain = 1'b1;
                if (status.drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ design/srrw_dp.sv @@
module srrw_dp
    import srrw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  request_t request,
    input  cmd_t     cmd,
    output status_t  status,
    output logic     result_strobe,
    output result_t  result
);

    request_t               req_reg;
    logic [SEQ_BITS-1:0]    base_reg;
    logic [WINDOW-1:0]      held_reg;
    logic                   over_reg;
    logic [SLOT_BITS-1:0]   cnt_reg;
    logic [TAG_BITS-1:0]    slot_handle_reg [WINDOW];
    logic                   slot_final_reg  [WINDOW];
    logic                   strobe_reg;
    result_t                result_reg;

    logic [SEQ_BITS:0]      seq_ext;
    logic [SEQ_BITS:0]      base_ext;
    logic [SEQ_BITS:0]      low_ext;
    logic                   in_win;
    logic                   dup;
    logic                   is_base;
    logic [SLOT_BITS-1:0]   seq_slot;
    logic [SLOT_BITS-1:0]   cur_slot;
    logic [SLOT_BITS-1:0]   nxt_slot;
    logic [TAG_BITS-1:0]    cur_handle;
    logic                   cur_final;
    logic                   drain_last;

    assign seq_ext  = {1'b0, req_reg.seq_no};
    assign base_ext = {1'b0, base_reg};
    assign low_ext  = (base_ext >= (SEQ_BITS+1)'(WINDOW)) ?
                      (base_ext - (SEQ_BITS+1)'(WINDOW)) : '0;
    assign in_win   = (seq_ext >= base_ext) && (seq_ext < base_ext + (SEQ_BITS+1)'(WINDOW));
    assign dup      = (seq_ext < base_ext) && (seq_ext >= low_ext);
    assign is_base  = (req_reg.seq_no == base_reg);
    assign seq_slot = req_reg.seq_no[SLOT_BITS-1:0];

    assign cur_slot   = base_reg[SLOT_BITS-1:0];
    assign nxt_slot   = cur_slot + SLOT_BITS'(1);
    assign cur_handle = slot_handle_reg[cur_slot];
    assign cur_final  = slot_final_reg[cur_slot];

    // last delivery: final packet, top seq or end of held run
    assign drain_last = cur_final || (base_reg == SEQ_MAX)
                     || (cnt_reg == SLOT_BITS'(WINDOW - 1))
                     || !(held_reg[nxt_slot] && (nxt_slot != cur_slot));

    assign status.in_win       = in_win;
    assign status.is_base      = is_base;
    assign status.session_over = over_reg;
    assign status.drain_last   = drain_last;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= request;
        end
        if (cmd.eval && !over_reg && in_win && !held_reg[seq_slot])
        begin
            slot_handle_reg[seq_slot] <= req_reg.payload_tag;
            slot_final_reg[seq_slot]  <= req_reg.final_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            held_reg <= '0;
            over_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.eval)
        begin
            cnt_reg <= '0;
            if (!over_reg && in_win)
            begin
                held_reg[seq_slot] <= 1'b1;
            end
        end
        else if (cmd.drain)
        begin
            held_reg[cur_slot] <= 1'b0;
            cnt_reg            <= cnt_reg + SLOT_BITS'(1);
            if (cur_final)
            begin
                over_reg <= 1'b1;
            end
            else if (base_reg != SEQ_MAX)
            begin
                base_reg <= base_reg + SEQ_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.eval && !over_reg && (in_win || dup)) || cmd.drain;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            result_reg.kind      <= KIND_ACK;
            result_reg.out_seq   <= req_reg.seq_no;
            result_reg.ack_check <= req_reg.payload_check;
            result_reg.out_tag   <= '0;
            result_reg.file_done <= 1'b0;
            result_reg.run_end   <= !(in_win && is_base);
        end
        else if (cmd.drain)
        begin
            result_reg.kind      <= KIND_DELIVER;
            result_reg.out_seq   <= base_reg;
            result_reg.ack_check <= '0;
            result_reg.out_tag   <= cur_handle;
            result_reg.file_done <= cur_final;
            result_reg.run_end   <= drain_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

@@ design/selective_repeat_receive_window.sv @@
// Channel   Handshake            Payload     Notes
// request   start / busy         request_t   taken when start && !busy
// result    result_strobe        result_t    strobe marks each result, no back-pressure
//
// A request is latched, then evaluated; when it fills the window base the
// drain loop follows with one in-order delivery per held slot, at most
// WINDOW, reading one held slot per cycle. Results are registered.
// Reset clears window base, held flags and the session flag; no clearing pass.
// Results cannot be stalled; once the session is over requests yield nothing.
module selective_repeat_receive_window
    import srrw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_strobe,
    output result_t  result
);

    cmd_t    cmd;
    status_t status;

    srrw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    srrw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import srrw_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SEQ_SPAN    = 1 << SEQ_BITS;

    class receive_window_scoreboard;
        logic [SEQ_BITS-1:0] base;
        logic                held [WINDOW];
        logic [TAG_BITS-1:0] handle [WINDOW];
        logic                last_of_file [WINDOW];
        logic                over;
        result_t             owed_replies [$];
        int                  mismatches;

        function new();
            base = '0;
            over = 1'b0;
            mismatches = 0;
            foreach (held[i])
            begin
                held[i] = 1'b0;
                handle[i] = '0;
                last_of_file[i] = 1'b0;
            end
        endfunction

        function string describe(result_t r);
            return $sformatf("kind=%0d seq=%0d check=%0d tag=%h done=%0d end=%0d",
                             r.kind, r.out_seq, r.ack_check, r.out_tag, r.file_done,
                             r.run_end);
        endfunction

        // work out the ack and in-order deliveries one accepted request causes
        function void take_packet(request_t pkt);
            int unsigned s;
            int unsigned b;
            int unsigned low;
            int          slot;
            result_t     ack;
            result_t     dlv;
            result_t     batch [$];
            if (over)
                return;
            s = pkt.seq_no;
            b = base;
            low = (b >= WINDOW) ? b - WINDOW : 0;
            ack = '0;
            ack.kind = KIND_ACK;
            ack.out_seq = pkt.seq_no;
            ack.ack_check = pkt.payload_check;
            if (s >= b && s < b + WINDOW)
            begin
                slot = s % WINDOW;
                batch = {batch, ack};
                if (!held[slot])
                begin
                    held[slot] = 1'b1;
                    handle[slot] = pkt.payload_tag;
                    last_of_file[slot] = pkt.final_packet;
                end
                if (s == b)
                begin
                    while (batch.size() < WINDOW + 1)
                    begin
                        slot = base % WINDOW;
                        if (!held[slot])
                            break;
                        held[slot] = 1'b0;
                        dlv = '0;
                        dlv.kind = KIND_DELIVER;
                        dlv.out_seq = base;
                        dlv.out_tag = handle[slot];
                        dlv.file_done = last_of_file[slot];
                        batch = {batch, dlv};
                        if (last_of_file[slot])
                        begin
                            over = 1'b1;
                            break;
                        end
                        // base saturates: a packet at the top is delivered in place
                        if (base == SEQ_MAX)
                            break;
                        base++;
                    end
                end
            end
            else if (s < b && s >= low)
            begin
                batch = {batch, ack};
            end
            if (batch.size() > 0)
                batch[batch.size()-1].run_end = 1'b1;
            foreach (batch[i])
                owed_replies = {owed_replies, batch[i]};
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (owed_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = owed_replies.pop_front();
            if (got.kind !== want.kind || got.out_seq !== want.out_seq ||
                got.ack_check !== want.ack_check || got.out_tag !== want.out_tag ||
                got.file_done !== want.file_done || got.run_end !== want.run_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %s, got %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     result_strobe;
    request_t request;
    result_t  result;

    receive_window_scoreboard sb = new();

    selective_repeat_receive_window dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
                sb.check_reply(result);
            if (start && !busy)
                sb.take_packet(request);
        end
    end

    function automatic request_t packet(input logic [SEQ_BITS-1:0] seq, input logic fin,
                                        input logic [TAG_BITS-1:0] tag,
                                        input logic signed [CHK_BITS-1:0] chk);
        request_t p;
        p.seq_no = seq;
        p.final_packet = fin;
        p.payload_tag = tag;
        p.payload_check = chk;
        return p;
    endfunction

    // mostly packets near the window, some anywhere in the sequence space
    function automatic request_t random_packet();
        request_t    p;
        int unsigned b;
        int unsigned s;
        int          pick;
        b = sb.base;
        pick = $urandom_range(99);
        if (pick < 15)
            s = $urandom_range(SEQ_SPAN - 1);
        else if (pick < 40)
            s = b;
        else
            s = (b + SEQ_SPAN + $urandom_range(10) - 5) % SEQ_SPAN;
        p.seq_no = s[SEQ_BITS-1:0];
        p.payload_tag = $urandom;
        p.payload_check = CHK_BITS'($urandom_range(255));
        // keep last-of-file off anything that would be stored, or the session ends early
        if (s >= b && s < b + WINDOW && !sb.held[s % WINDOW])
            p.final_packet = 1'b0;
        else
            p.final_packet = 1'($urandom_range(1));
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_packet(input request_t pkt, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < 64 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        request <= pkt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_run(input int count, input int idle_pct);
        repeat (count) send_packet(random_packet(), idle_pct);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, base starts at zero
        send_packet(packet(16'd1, 1'b0, 32'hFFFF_FFFF, -8'sd128), 0);
        send_packet(packet(16'd1, 1'b1, 32'h0, 8'sd127), 0);          // already held
        send_packet(packet(16'd3, 1'b0, $urandom, 8'sd0), 0);
        send_packet(packet(16'd0, 1'b0, 32'h0, -8'sd1), 0);           // drains 0,1
        send_packet(packet(16'd0, 1'b1, $urandom, 8'sd5), 27);        // duplicate range clipped at 0
        send_packet(packet(16'd1, 1'b0, $urandom, -8'sd77), 0);
        send_packet(packet(SEQ_MAX, 1'b1, 32'hFFFF_FFFF, 8'sd127), 0); // dropped
        send_packet(packet(16'd6, 1'b1, $urandom, 8'sd1), 0);          // beyond window
        send_packet(packet(16'd2, 1'b0, $urandom, 8'sd33), 0);         // drains 2,3
        send_packet(packet(16'd7, 1'b0, $urandom, -8'sd128), 0);
        send_packet(packet(16'd6, 1'b0, $urandom, 8'sd127), 27);
        send_packet(packet(16'd5, 1'b0, 32'h0, 8'sd0), 0);
        send_packet(packet(16'd4, 1'b0, 32'hFFFF_FFFF, -8'sd1), 0);    // ack plus four deliveries
        send_packet(packet(16'd3, 1'b1, $urandom, 8'sd9), 0);          // below duplicate range
        send_packet(packet(16'd4, 1'b1, $urandom, 8'sd10), 0);
        send_packet(packet(16'd8, 1'b0, 32'hA5A5_5A5A, 8'sd85), 0);
        send_packet(packet(16'h8000, 1'b1, $urandom, -8'sd86), 0);
        send_packet(packet(16'h5555, 1'b0, 32'h5555_5555, 8'sd0), 0);
        send_packet(packet(16'hAAAA, 1'b1, 32'hAAAA_AAAA, 8'sd0), 0);

        random_run(50, 27);
        random_run(50, 58);
        random_run(50, 0);

        // end of file, then everything is ignored
        send_packet(packet(sb.base, 1'b1, $urandom, 8'sd99), 0);
        random_run(6, 27);
        start <= 1'b0;

        waited = 0;
        while (sb.owed_replies.size() > 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (sb.owed_replies.size() > 0)
        begin
            sb.mismatches++;
            $display("%0d expected results never arrived", sb.owed_replies.size());
        end
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ selective_repeat_receive_window.f @@
design/srrw_pkg.sv
design/srrw_ctrl.sv
design/srrw_dp.sv
design/selective_repeat_receive_window.sv
tb/tb_top.sv
